// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Clocked next-cycle implication with reset disable.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/tabsg_pkg.sv =====
// Package with the constants of the step generator.
`timescale 1ns / 1ps
package tabsg_pkg;
  localparam int unsigned Axes = 3;
  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpReset = 2'd1;
  localparam logic [1:0] OpZero = 2'd2;
  localparam logic [1:0] OpNop = 2'd3;
  localparam logic [1:0] KindMove = 2'd0;
  localparam logic [1:0] KindMoveTo = 2'd1;
  localparam logic [1:0] KindMoveAt = 2'd2;
  localparam logic [1:0] KindOther = 2'd3;
  localparam logic [7:0] TicksReset = 8'd10;
  localparam logic [9:0] MsScale = 10'd1000;
endpackage

// ===== rtl/three_axis_bresenham_step_generator_top.sv =====
// Top level of the three-axis Bresenham step pulse generator.
`timescale 1ns / 1ps
// Usage: each input item carries one opcode (timer tick, reset request, zero
// positions or no-op) together with a view of the motion queue head. Each item
// yields exactly one result item with step pulses, directions, the busy flag
// and the three 32-bit signed positions.
// Items are processed one at a time. Block setup uses serial units: a
// 48-step restoring division for 1000 * longest axis / speed and an 8-step
// shift-add multiply of ticks_per_ms and the duration. The Bresenham update
// of all three axes is done together in the S_FIN state.
// Non-tick opcodes, ticks with an empty queue and dropped blocks go straight
// to the result register. A tick on an active block or one that takes an
// other-kind block first passes the Bresenham update; a tick that takes a
// move or move-at block also runs the multiply before it, and a move-to
// block the division and the multiply.
// The result waits in an output register; a stall on the result channel
// holds it and the block takes no new item until it is taken.
// Reset clears positions, errors, counters and the active block, and sets
// ticks_per_ms to 10. Writes of ticks_per_ms are taken whenever cfg_we_i
// is high.
module three_axis_bresenham_step_generator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic               head_valid_i,
  input  logic [1:0]         head_type_i,
  input  logic signed [15:0] head_dx_i,
  input  logic signed [15:0] head_dy_i,
  input  logic signed [15:0] head_dz_i,
  input  logic signed [15:0] head_time_i,
  input  logic               more_queued_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               took_block_o,
  output logic               step_x_o,
  output logic               step_y_o,
  output logic               step_z_o,
  output logic               dir_x_o,
  output logic               dir_y_o,
  output logic               dir_z_o,
  output logic               busy_res_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_MAG, S_DIV, S_DUR, S_MUL, S_ERRI, S_BRES, S_FIN, S_OUT
  } state_e;

  state_e      state_q;
  logic [7:0]  tpm_q;
  logic [31:0] pos_q [3];
  logic [31:0] err_q [3];
  logic [31:0] dlt_q [3];
  logic [2:0]  neg_q;
  logic [31:0] seg_q;
  logic [7:0]  tick_q;
  logic [15:0] ms_q;
  logic        act_q;
  logic [1:0]  kind_q;
  logic [15:0] dur_q;
  // Latched item.
  logic [1:0]  ht_q;
  logic [15:0] hd_q [3];
  logic [15:0] ht16_q;
  // Serial engine.
  logic [5:0]  cnt_q;
  logic [2:0]  stp_q;
  logic        took_q, queued_q;
  // Division / multiply registers.
  logic [47:0] num_q;
  logic [16:0] rem_q;
  logic [15:0] dvs_q;
  logic        qneg_q;
  logic [31:0] acc_q;
  logic [31:0] mcand_q;
  logic [7:0]  mplr_q;

  assign in_stall_o = (state_q != S_IDLE);

  logic [31:0] mx;
  logic [31:0] m01;
  always_comb begin
    m01 = (dlt_q[0] > dlt_q[1]) ? dlt_q[0] : dlt_q[1];
    mx  = (m01 > dlt_q[2]) ? m01 : dlt_q[2];
  end

  // Divider step on the 17-bit remainder.
  logic [16:0] rsh;
  logic [16:0] rsub;
  always_comb begin
    rsh  = {rem_q[15:0], num_q[47]};
    rsub = rsh - {1'b0, dvs_q};
  end

  logic [15:0] quo16;
  assign quo16 = qneg_q ? (16'd0 - num_q[15:0]) : num_q[15:0];

  // Half of the new segment length, rounded toward zero.
  logic [31:0] half;
  assign half = {acc_q[31], acc_q[31:1]} + {31'd0, acc_q[31] & acc_q[0]};

  logic [7:0] tick_inc;
  assign tick_inc = tick_q + 8'd1;
  logic [15:0] ms_next;
  assign ms_next = (tick_inc == tpm_q) ? ms_q + 16'd1 : ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tpm_q <= tabsg_pkg::TicksReset;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        err_q[i] <= '0;
        dlt_q[i] <= '0;
      end
      neg_q <= '0;
      seg_q <= '0;
      tick_q <= '0;
      ms_q <= '0;
      act_q <= 1'b0;
      kind_q <= '0;
      dur_q <= '0;
      out_valid_o <= 1'b0;
      cnt_q <= '0;
      stp_q <= '0;
      took_q <= 1'b0;
      queued_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpm_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ht_q <= head_type_i;
            hd_q[0] <= head_dx_i;
            hd_q[1] <= head_dy_i;
            hd_q[2] <= head_dz_i;
            ht16_q <= head_time_i;
            stp_q <= '0;
            took_q <= 1'b0;
            queued_q <= head_valid_i;
            if (opcode_i == tabsg_pkg::OpReset) begin
              act_q <= 1'b0;
              tick_q <= '0;
              ms_q <= '0;
              state_q <= S_OUT;
            end else if (opcode_i == tabsg_pkg::OpZero) begin
              for (int i = 0; i < 3; i++) begin
                pos_q[i] <= '0;
                err_q[i] <= '0;
              end
              state_q <= S_OUT;
            end else if (opcode_i != tabsg_pkg::OpTick) begin
              state_q <= S_OUT;
            end else if (!act_q && head_valid_i) begin
              took_q <= 1'b1;
              queued_q <= more_queued_i;
              tick_q <= '0;
              ms_q <= '0;
              if (head_type_i == tabsg_pkg::KindOther) begin
                act_q <= 1'b1;
                kind_q <= tabsg_pkg::KindOther;
                state_q <= S_FIN;
              end else if ((head_type_i == tabsg_pkg::KindMove &&
                            (head_time_i[15] || head_time_i == 16'sd0)) ||
                           (head_type_i == tabsg_pkg::KindMoveTo &&
                            head_time_i == 16'sd0)) begin
                state_q <= S_OUT;
              end else begin
                state_q <= S_MAG;
              end
            end else if (!act_q) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_MAG: begin
          // Axis deltas and directions of the new block.
          for (int i = 0; i < 3; i++) begin
            logic [31:0] d;
            d = {{16{hd_q[i][15]}}, hd_q[i]};
            if (ht_q == tabsg_pkg::KindMoveTo) begin
              d = d - pos_q[i];
            end
            neg_q[i] <= d[31];
            dlt_q[i] <= d[31] ? 32'd0 - d : d;
          end
          kind_q <= ht_q;
          act_q <= 1'b1;
          cnt_q <= '0;
          if (ht_q == tabsg_pkg::KindMoveTo) begin
            state_q <= S_DIV;
          end else begin
            dur_q <= ht16_q;
            state_q <= S_DUR;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            // The product fits in 42 bits; magnitude of the speed divides it.
            num_q <= ({16'd0, mx} << 10) - ({16'd0, mx} << 4) - ({16'd0, mx} << 3);
            rem_q <= '0;
            dvs_q <= ht16_q[15] ? 16'd0 - ht16_q : ht16_q;
            qneg_q <= ht16_q[15];
            cnt_q <= 6'd1;
          end else begin
            if (!rsub[16]) begin
              rem_q <= rsub;
              num_q <= {num_q[46:0], 1'b1};
            end else begin
              rem_q <= rsh;
              num_q <= {num_q[46:0], 1'b0};
            end
            if (cnt_q == 6'd48) begin
              state_q <= S_DUR;
            end
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_DUR: begin
          if (kind_q == tabsg_pkg::KindMoveTo) begin
            dur_q <= quo16;
            mcand_q <= {{16{quo16[15]}}, quo16};
          end else begin
            mcand_q <= {{16{dur_q[15]}}, dur_q};
          end
          mplr_q <= tpm_q;
          acc_q <= '0;
          cnt_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          // Shift-add product of ticks_per_ms and the duration.
          if (mplr_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q <= mcand_q << 1;
          mplr_q <= mplr_q >> 1;
          if (cnt_q == 6'd7) begin
            state_q <= S_ERRI;
          end
          cnt_q <= cnt_q + 6'd1;
        end
        S_ERRI: begin
          seg_q <= acc_q;
          for (int i = 0; i < 3; i++) begin
            err_q[i] <= dlt_q[i] - half;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          tick_q <= (tick_inc == tpm_q) ? 8'd0 : tick_inc;
          ms_q <= ms_next;
          if (act_q && kind_q != tabsg_pkg::KindOther) begin
            for (int i = 0; i < 3; i++) begin
              if (!err_q[i][31] && err_q[i] != 32'd0) begin
                stp_q[i] <= 1'b1;
                pos_q[i] <= pos_q[i] + (neg_q[i] ? 32'hFFFF_FFFF : 32'd1);
                err_q[i] <= err_q[i] - seg_q + dlt_q[i];
              end else begin
                err_q[i] <= err_q[i] + dlt_q[i];
              end
            end
            if (kind_q == tabsg_pkg::KindMoveAt) begin
              if (queued_q) act_q <= 1'b0;
            end else if ($signed(ms_next) >= $signed(dur_q)) begin
              act_q <= 1'b0;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
          end else if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign took_block_o = took_q;
  assign step_x_o = stp_q[0];
  assign step_y_o = stp_q[1];
  assign step_z_o = stp_q[2];
  assign dir_x_o = neg_q[0];
  assign dir_y_o = neg_q[1];
  assign dir_z_o = neg_q[2];
  assign busy_res_o = act_q | queued_q;
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
endmodule

// ===== rtl/tabsg_checker.sv =====
// Port-level checker for the step generator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tabsg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [31:0] pos_x_o
);
  // One item in flight: no input accepted while a result is shown.
  `ASSERT_IMPL(a_no_accept_with_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  // A stalled result keeps its x position.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(pos_x_o))
  // A stalled result stays offered.
  `ASSERT_NEXT(a_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
endmodule

bind three_axis_bresenham_step_generator_top tabsg_checker u_chk (.*);
